// File: rtl/db8_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and filter taps for the db8 line analysis block.
package db8_pkg;

    localparam int TAPS          = 16;
    localparam int TAP_AW        = $clog2(TAPS);
    localparam int SMP_W         = 16;
    localparam int IDX_W         = 11;
    localparam int COEF_W        = 38;
    localparam int TAP_W         = 22;
    localparam int BURST_MAX     = 8;
    localparam int CNT_W         = 4;
    localparam int FIRST_OUT_POS = TAPS - 3;
    localparam int SUM_GRP       = 4;
    localparam int SUM_NGRP      = TAPS / SUM_GRP;

    typedef logic signed [SMP_W-1:0]  smp_t;
    typedef logic signed [TAP_W-1:0]  tap_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic        [IDX_W-1:0]  idx_t;
    typedef tap_t tap_array_t [TAPS];

    // db8 analysis taps, scaled by 2^20
    localparam tap_array_t LO_TAPS = '{
        tap_t'(-123),    tap_t'(708),     tap_t'(-410),    tap_t'(-5106),
        tap_t'(9170),    tap_t'(14660),   tap_t'(-46229),  tap_t'(-18213),
        tap_t'(135001),  tap_t'(495),     tap_t'(-297811), tap_t'(-16598),
        tap_t'(613788),  tap_t'(708450),  tap_t'(328069),  tap_t'(57059)
    };

    localparam tap_array_t HI_TAPS = '{
        tap_t'(-57059),  tap_t'(328069),  tap_t'(-708450), tap_t'(613788),
        tap_t'(16598),   tap_t'(-297811), tap_t'(-495),    tap_t'(135001),
        tap_t'(18213),   tap_t'(-46229),  tap_t'(-14660),  tap_t'(9170),
        tap_t'(5106),    tap_t'(-410),    tap_t'(-708),    tap_t'(-123)
    };

endpackage

// File: rtl/db8_dwt_analysis_line.sv
`timescale 1ns / 1ps
// One level of 16-tap db8 wavelet analysis over a line of signed samples.
//
// Takes one sample per clock while sample_ready is high. Each odd-position
// sample from position 15 on yields one low/high coefficient pair; position
// 13 yields outputs 0..6 and the last sample of a line yields the remaining
// 8 outputs, the final one flagged with line_done. A burst sequencer issues
// one output per cycle, unless coef_ready stalls it, into a four-stage
// pipeline (window gather with edge mirroring, constant multiplies, partial
// sums, final sum), so results stream at one per cycle while coef_ready is
// high. During a burst sample_ready stays low until its last output issues.
// Sums are given unshifted (taps scaled by 2^20). Lines must hold at least
// 16 samples; a sample at position MAX_LINE-1 ends the line regardless of
// last_sample.
module db8_dwt_analysis_line #(
    parameter int MAX_LINE = 2048
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           sample_valid,
    output logic           sample_ready,
    input  db8_pkg::smp_t  sample,
    input  logic           last_sample,
    output logic           coef_valid,
    input  logic           coef_ready,
    output db8_pkg::idx_t  coef_index,
    output db8_pkg::coef_t low_coef,
    output db8_pkg::coef_t high_coef,
    output logic           line_done
);

    import db8_pkg::*;

    localparam int PW = $clog2(MAX_LINE);
    localparam int KW = PW + 3;

    // line position and output bookkeeping
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    nout_reg, nout_next;
    logic [PW-1:0]    job_idx_reg, job_idx_next;
    logic [PW-1:0]    job_p_reg, job_p_next;
    logic [CNT_W-1:0] job_cnt_reg, job_cnt_next;
    logic             job_last_reg, job_last_next;

    smp_t win_reg [TAPS];

    logic             accept;
    logic             issue;
    logic             force_last;
    logic [PW:0]      stop;
    logic [PW:0]      diff;
    logic [CNT_W-1:0] burst;

    logic en1, en2, en3, en_out;

    // gather lanes
    logic signed [KW-1:0] job_i_s, job_p_s;
    logic signed [KW-1:0] lane_k   [TAPS];
    logic signed [KW-1:0] lane_idx [TAPS];
    logic signed [KW-1:0] lane_d   [TAPS];
    smp_t                 gath     [TAPS];

    // pipeline
    logic  s1_valid_reg, s2_valid_reg, s3_valid_reg, coef_valid_reg;
    smp_t  s1_smp_reg [TAPS];
    idx_t  s1_idx_reg, s2_idx_reg, s3_idx_reg, coef_index_reg;
    logic  s1_done_reg, s2_done_reg, s3_done_reg, line_done_reg;
    coef_t lo_prod  [TAPS];
    coef_t hi_prod  [TAPS];
    coef_t s2_lo_reg [TAPS];
    coef_t s2_hi_reg [TAPS];
    coef_t psum_lo  [SUM_NGRP];
    coef_t psum_hi  [SUM_NGRP];
    coef_t s3_lo_reg [SUM_NGRP];
    coef_t s3_hi_reg [SUM_NGRP];
    coef_t sum_lo, sum_hi;
    coef_t low_coef_reg, high_coef_reg;

    // stall chain from the output register back to the sequencer
    assign en_out = !coef_valid_reg || coef_ready;
    assign en3    = !s3_valid_reg || en_out;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;

    assign issue        = (job_cnt_reg != '0) && en1;
    assign sample_ready = (job_cnt_reg == '0) || ((job_cnt_reg == CNT_W'(1)) && en1);
    assign accept       = sample_valid && sample_ready;

    assign force_last = last_sample || (pos_reg == PW'(MAX_LINE - 1));

    always_comb
    begin
        if (force_last)
        begin
            stop = ({1'b0, pos_reg} + (PW+1)'(TAPS)) >> 1;
        end
        else if (pos_reg[0] && (pos_reg >= PW'(FIRST_OUT_POS)))
        begin
            stop = ({1'b0, pos_reg} + (PW+1)'(1)) >> 1;
        end
        else
        begin
            stop = {1'b0, nout_reg};
        end
        diff  = stop - {1'b0, nout_reg};
        burst = (diff > (PW+1)'(BURST_MAX)) ? CNT_W'(BURST_MAX) : diff[CNT_W-1:0];
    end

    always_comb
    begin
        pos_next      = pos_reg;
        nout_next     = nout_reg;
        job_idx_next  = job_idx_reg;
        job_p_next    = job_p_reg;
        job_cnt_next  = job_cnt_reg;
        job_last_next = job_last_reg;
        if (issue)
        begin
            job_idx_next = job_idx_reg + 1'b1;
            job_cnt_next = job_cnt_reg - 1'b1;
        end
        if (accept)
        begin
            pos_next      = force_last ? '0 : pos_reg + 1'b1;
            nout_next     = force_last ? '0 : nout_reg + PW'(burst);
            job_idx_next  = nout_reg;
            job_p_next    = pos_reg;
            job_cnt_next  = burst;
            job_last_next = force_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            nout_reg       <= '0;
            job_idx_reg    <= '0;
            job_p_reg      <= '0;
            job_cnt_reg    <= '0;
            job_last_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            coef_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            nout_reg     <= nout_next;
            job_idx_reg  <= job_idx_next;
            job_p_reg    <= job_p_next;
            job_cnt_reg  <= job_cnt_next;
            job_last_reg <= job_last_next;
            if (en1)
            begin
                s1_valid_reg <= issue;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                coef_valid_reg <= s3_valid_reg;
            end
        end
    end

    // win_reg[d] holds the sample at position (newest - d)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg[0] <= sample;
            for (int t = 1; t < TAPS; t++)
            begin
                win_reg[t] <= win_reg[t-1];
            end
        end
    end

    // Mirror each tap index into the line and pick it from the window;
    // indices that fall outside the line or the window read as zero.
    assign job_i_s = KW'(job_idx_reg);
    assign job_p_s = KW'(job_p_reg);

    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            lane_k[j] = (job_i_s <<< 1) + KW'(1) - KW'(j);
            if (lane_k[j] < 0)
            begin
                lane_idx[j] = -lane_k[j] - KW'(1);
            end
            else if (lane_k[j] > job_p_s)
            begin
                lane_idx[j] = (job_p_s <<< 1) + KW'(1) - lane_k[j];
            end
            else
            begin
                lane_idx[j] = lane_k[j];
            end
            lane_d[j] = job_p_s - lane_idx[j];
            if ((lane_idx[j] >= 0) && (lane_d[j] >= 0) && (lane_d[j] <= KW'(TAPS - 1)))
            begin
                gath[j] = win_reg[lane_d[j][TAP_AW-1:0]];
            end
            else
            begin
                gath[j] = '0;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            lo_prod[j] = coef_t'(s1_smp_reg[j]) * coef_t'(LO_TAPS[j]);
            hi_prod[j] = coef_t'(s1_smp_reg[j]) * coef_t'(HI_TAPS[j]);
        end
    end

    always_comb
    begin
        for (int g = 0; g < SUM_NGRP; g++)
        begin
            psum_lo[g] = '0;
            psum_hi[g] = '0;
            for (int m = 0; m < SUM_GRP; m++)
            begin
                psum_lo[g] = psum_lo[g] + s2_lo_reg[g*SUM_GRP + m];
                psum_hi[g] = psum_hi[g] + s2_hi_reg[g*SUM_GRP + m];
            end
        end
    end

    always_comb
    begin
        sum_lo = '0;
        sum_hi = '0;
        for (int g = 0; g < SUM_NGRP; g++)
        begin
            sum_lo = sum_lo + s3_lo_reg[g];
            sum_hi = sum_hi + s3_hi_reg[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_smp_reg  <= gath;
            s1_idx_reg  <= IDX_W'(job_idx_reg);
            s1_done_reg <= job_last_reg && (job_cnt_reg == CNT_W'(1));
        end
        if (en2 && s1_valid_reg)
        begin
            s2_lo_reg   <= lo_prod;
            s2_hi_reg   <= hi_prod;
            s2_idx_reg  <= s1_idx_reg;
            s2_done_reg <= s1_done_reg;
        end
        if (en3 && s2_valid_reg)
        begin
            s3_lo_reg   <= psum_lo;
            s3_hi_reg   <= psum_hi;
            s3_idx_reg  <= s2_idx_reg;
            s3_done_reg <= s2_done_reg;
        end
        if (en_out && s3_valid_reg)
        begin
            low_coef_reg   <= sum_lo;
            high_coef_reg  <= sum_hi;
            coef_index_reg <= s3_idx_reg;
            line_done_reg  <= s3_done_reg;
        end
    end

    assign coef_valid = coef_valid_reg;
    assign coef_index = coef_index_reg;
    assign low_coef   = low_coef_reg;
    assign high_coef  = high_coef_reg;
    assign line_done  = line_done_reg;

endmodule

// File: rtl/db8_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the db8 line analysis block, bound to the top level.
module db8_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           sample_valid,
    input logic           sample_ready,
    input logic           last_sample,
    input logic           coef_valid,
    input logic           coef_ready,
    input db8_pkg::idx_t  coef_index,
    input db8_pkg::coef_t low_coef,
    input db8_pkg::coef_t high_coef,
    input logic           line_done
);

    import db8_pkg::*;

    logic out_acc;
    logic seen_reg;
    logic prev_done_reg;
    idx_t prev_idx_reg;

    assign out_acc = coef_valid && coef_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            prev_done_reg <= 1'b0;
            prev_idx_reg  <= '0;
        end
        else if (out_acc)
        begin
            seen_reg      <= 1'b1;
            prev_done_reg <= line_done;
            prev_idx_reg  <= coef_index;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && !coef_ready |=> coef_valid && $stable(coef_index)
            && $stable(low_coef) && $stable(high_coef) && $stable(line_done))
        else $error("result changed while stalled");

    // a line's results start at index zero
    a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && (!seen_reg || prev_done_reg) |-> coef_index == '0)
        else $error("line did not start at index zero");

    // within a line the indices follow one another
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg && !prev_done_reg |-> coef_index == prev_idx_reg + 1'b1)
        else $error("result index skipped or repeated");

    // the tail burst after a line's last sample holds off input
    a_tail_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && last_sample |=> !sample_ready)
        else $error("input taken during tail burst");

endmodule

bind db8_dwt_analysis_line db8_checker u_db8_checker (.*);
